@@ sv/sps_pkg.sv @@
// sps_pkg: shared types, codes and coil duty tables for the stepper phase sequencer
// depends on nothing; used by sps_row_rom and stepper_phase_sequencer_top
package sps_pkg;

  // drive mode register codes
  typedef enum logic [1:0] {
    MODE_FULL  = 2'd0,
    MODE_WAVE  = 2'd1,
    MODE_HALF  = 2'd2,
    MODE_MICRO = 2'd3
  } drive_mode_t;

  // request codes of an input transaction
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_SPEED = 2'd1;
  localparam logic [1:0] REQ_DIR   = 2'd2;

  // state widths and reset values
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned PERIOD_W = 12;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 12'd50;
  localparam drive_mode_t MODE_RESET = MODE_MICRO;

  // last row of each table, used as index mask and wrap point
  localparam logic [IDX_W-1:0] LAST_ROW_4  = 4'd3;
  localparam logic [IDX_W-1:0] LAST_ROW_8  = 4'd7;
  localparam logic [IDX_W-1:0] LAST_ROW_16 = 4'd15;

  // speed law offsets
  localparam logic [PERIOD_W-1:0] OFS_FULL  = 12'd20;
  localparam logic [PERIOD_W-1:0] OFS_HALF  = 12'd10;
  localparam logic [PERIOD_W-1:0] OFS_MICRO = 12'd8;

  typedef logic [6:0] duty_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] speed_level;
  } in_t;

  typedef struct packed {
    duty_t coil_duty_a;
    duty_t coil_duty_b;
    duty_t coil_duty_c;
    duty_t coil_duty_d;
  } out_t;

  // duty levels in percent
  localparam duty_t D00 = 7'd0;
  localparam duty_t D38 = 7'd38;
  localparam duty_t D71 = 7'd71;
  localparam duty_t D92 = 7'd92;
  localparam duty_t D99 = 7'd99;

  localparam out_t FULL_ROWS [4] = '{
    '{D99, D00, D99, D00}, '{D99, D00, D00, D99},
    '{D00, D99, D00, D99}, '{D00, D99, D99, D00}};

  localparam out_t WAVE_ROWS [4] = '{
    '{D99, D00, D00, D00}, '{D00, D00, D00, D99},
    '{D00, D99, D00, D00}, '{D00, D00, D99, D00}};

  localparam out_t HALF_ROWS [8] = '{
    '{D99, D00, D99, D00}, '{D99, D00, D00, D00},
    '{D99, D00, D00, D99}, '{D00, D00, D00, D99},
    '{D00, D99, D00, D99}, '{D00, D99, D00, D00},
    '{D00, D99, D99, D00}, '{D00, D00, D99, D00}};

  localparam out_t MICRO_ROWS [16] = '{
    '{D71, D00, D71, D00}, '{D92, D00, D38, D00},
    '{D99, D00, D00, D00}, '{D92, D00, D00, D38},
    '{D71, D00, D00, D71}, '{D38, D00, D00, D92},
    '{D00, D00, D00, D99}, '{D00, D38, D00, D92},
    '{D00, D71, D00, D71}, '{D00, D92, D00, D38},
    '{D00, D99, D00, D00}, '{D00, D92, D38, D00},
    '{D00, D71, D71, D00}, '{D00, D38, D92, D00},
    '{D00, D00, D99, D00}, '{D38, D00, D92, D00}};

endpackage

@@ sv/sps_row_rom.sv @@
// sps_row_rom: coil duty row lookup and index stepping for the current drive mode
// depends on sps_pkg (tables, mode codes, index widths)
module sps_row_rom (
  input  sps_pkg::drive_mode_t         mode,
  input  logic [sps_pkg::IDX_W-1:0]    step_index,
  input  logic                         forward,
  output sps_pkg::out_t                row,
  output logic [sps_pkg::IDX_W-1:0]    next_index
);

  logic [sps_pkg::IDX_W-1:0] last_row;
  logic [sps_pkg::IDX_W-1:0] idx;

  // table length by mode
  always_comb begin
    case (mode)
      sps_pkg::MODE_FULL:  last_row = sps_pkg::LAST_ROW_4;
      sps_pkg::MODE_WAVE:  last_row = sps_pkg::LAST_ROW_4;
      sps_pkg::MODE_HALF:  last_row = sps_pkg::LAST_ROW_8;
      default:             last_row = sps_pkg::LAST_ROW_16;
    endcase
  end

  assign idx = step_index & last_row;

  // row select
  always_comb begin
    case (mode)
      sps_pkg::MODE_FULL:  row = sps_pkg::FULL_ROWS[idx[1:0]];
      sps_pkg::MODE_WAVE:  row = sps_pkg::WAVE_ROWS[idx[1:0]];
      sps_pkg::MODE_HALF:  row = sps_pkg::HALF_ROWS[idx[2:0]];
      default:             row = sps_pkg::MICRO_ROWS[idx];
    endcase
  end

  // step forward or back with wrap at the table end
  always_comb begin
    if (forward) begin
      next_index = (idx == last_row) ? '0 : idx + 1'b1;
    end else begin
      next_index = (idx == '0) ? last_row : idx - 1'b1;
    end
  end

endmodule

@@ sv/stepper_phase_sequencer_top.sv @@
// stepper_phase_sequencer_top: stepper coil sequencer with valid/stall channels
// depends on sps_pkg and sps_row_rom
//
// Takes one input transaction per cycle unless in_stall is high: ticks count down the step period,
// speed updates load a new period for the next reload, direction items flip
// the step direction. A tick that ends the period emits the current row of
// coil duties through the input register and then the result register, and
// advances the row index. The input register and the result register each hold
// one transaction, so one more item is taken while a result waits on a stalled
// output. A drive_mode write clears the row index and must only be issued while
// no transaction is in flight.
module stepper_phase_sequencer_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [1:0]    cfg_wr_data,
  input  logic          in_valid,
  output logic          in_stall,
  input  sps_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output sps_pkg::out_t out_data
);

  sps_pkg::drive_mode_t             mode_r;
  logic [sps_pkg::IDX_W-1:0]        index_r, index_nxt;
  logic                             forward_r, forward_nxt;
  logic [sps_pkg::PERIOD_W-1:0]     period_r, period_nxt;
  logic [sps_pkg::PERIOD_W-1:0]     ticks_r, ticks_nxt;

  logic                             in_valid_r;
  sps_pkg::in_t                     in_data_r;
  logic                             out_valid_r, out_valid_nxt;
  sps_pkg::out_t                    out_data_r;

  logic                             proc_stall;
  logic                             fire;
  logic                             emit;
  sps_pkg::out_t                    row;
  logic [sps_pkg::IDX_W-1:0]        rom_next_index;
  logic [sps_pkg::PERIOD_W-1:0]     level_ext;
  logic [sps_pkg::PERIOD_W-1:0]     new_period;

  // handshake
  assign proc_stall = out_valid_r & out_stall;
  assign in_stall   = in_valid_r & proc_stall;
  assign fire       = in_valid_r & ~proc_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= (in_valid & ~in_stall) | in_valid_r & proc_stall;
    end
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  sps_row_rom u_row_rom (
    .mode       (mode_r),
    .step_index (index_r),
    .forward    (forward_r),
    .row        (row),
    .next_index (rom_next_index)
  );

  // speed law by mode
  assign level_ext = {{(sps_pkg::PERIOD_W-8){1'b0}}, in_data_r.speed_level};
  always_comb begin
    case (mode_r)
      sps_pkg::MODE_FULL,
      sps_pkg::MODE_WAVE: new_period = (level_ext << 3) + (level_ext << 1) + sps_pkg::OFS_FULL;
      sps_pkg::MODE_HALF: new_period = (level_ext << 3) + (level_ext << 1) + sps_pkg::OFS_HALF;
      default:            new_period = (level_ext << 2) + sps_pkg::OFS_MICRO;
    endcase
  end

  // transaction processing
  always_comb begin
    emit        = 1'b0;
    index_nxt   = index_r;
    forward_nxt = forward_r;
    period_nxt  = period_r;
    ticks_nxt   = ticks_r;
    if (fire) begin
      case (in_data_r.req_type)
        sps_pkg::REQ_TICK: begin
          if (ticks_r > sps_pkg::PERIOD_W'(1)) begin
            ticks_nxt = ticks_r - 1'b1;
          end else begin
            emit      = 1'b1;
            index_nxt = rom_next_index;
            ticks_nxt = period_r;
          end
        end
        sps_pkg::REQ_SPEED: period_nxt  = new_period;
        sps_pkg::REQ_DIR:   forward_nxt = ~forward_r;
        default:            ;
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= sps_pkg::MODE_RESET;
      index_r   <= '0;
      forward_r <= 1'b1;
      period_r  <= sps_pkg::PERIOD_RESET;
      ticks_r   <= sps_pkg::PERIOD_RESET;
    end else begin
      forward_r <= forward_nxt;
      period_r  <= period_nxt;
      ticks_r   <= ticks_nxt;
      if (cfg_wr_en) begin
        mode_r  <= sps_pkg::drive_mode_t'(cfg_wr_data);
        index_r <= '0;
      end else begin
        index_r <= index_nxt;
      end
    end
  end

  // result register
  assign out_valid_nxt = emit | (out_valid_r & out_stall);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (emit) begin
      out_data_r <= row;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sim/testbench.sv @@
// testbench for stepper_phase_sequencer_top: random and directed tick, speed and direction
// traffic with a transaction-level predictor; depends on sps_pkg and the sequencer rtl
`timescale 1ns / 1ps

module testbench;

  // request code the block ignores
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MIN_ITEMS = 1750;
  localparam int MAX_ITEMS = 12000;
  localparam int MIN_ROWS = 60;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_REPORTS = 50;

  // coil duty rows: full 0-3, wave 4-7, half 8-15, micro 16-31
  localparam int COIL_TAB [32][4] = '{
    '{99, 0, 99, 0}, '{99, 0, 0, 99}, '{0, 99, 0, 99}, '{0, 99, 99, 0},
    '{99, 0, 0, 0}, '{0, 0, 0, 99}, '{0, 99, 0, 0}, '{0, 0, 99, 0},
    '{99, 0, 99, 0}, '{99, 0, 0, 0}, '{99, 0, 0, 99}, '{0, 0, 0, 99},
    '{0, 99, 0, 99}, '{0, 99, 0, 0}, '{0, 99, 99, 0}, '{0, 0, 99, 0},
    '{71, 0, 71, 0}, '{92, 0, 38, 0}, '{99, 0, 0, 0}, '{92, 0, 0, 38},
    '{71, 0, 0, 71}, '{38, 0, 0, 92}, '{0, 0, 0, 99}, '{0, 38, 0, 92},
    '{0, 71, 0, 71}, '{0, 92, 0, 38}, '{0, 99, 0, 0}, '{0, 92, 38, 0},
    '{0, 71, 71, 0}, '{0, 38, 92, 0}, '{0, 0, 99, 0}, '{38, 0, 92, 0}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = 2'd0;
  logic in_valid = 1'b0;
  logic in_stall;
  sps_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sps_pkg::out_t out_data;

  stepper_phase_sequencer_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sps_pkg::in_t pending_items[$];
  sps_pkg::out_t expected_rows[$];
  int items_queued = 0;
  int rows_predicted = 0;
  int mismatches = 0;
  int cycle_count = 0;

  // sequencer state mirror
  sps_pkg::drive_mode_t seq_mode = sps_pkg::MODE_RESET;
  logic [3:0] seq_index = 4'd0;
  logic seq_forward = 1'b1;
  logic [11:0] seq_period = 12'd50;
  logic [11:0] seq_ticks = 12'd50;

  function automatic int table_rows(sps_pkg::drive_mode_t m);
    case (m)
      sps_pkg::MODE_FULL, sps_pkg::MODE_WAVE: return 4;
      sps_pkg::MODE_HALF: return 8;
      default: return 16;
    endcase
  endfunction

  function automatic sps_pkg::out_t coil_row(sps_pkg::drive_mode_t m, int idx);
    int base;
    sps_pkg::out_t row;
    case (m)
      sps_pkg::MODE_FULL: base = 0;
      sps_pkg::MODE_WAVE: base = 4;
      sps_pkg::MODE_HALF: base = 8;
      default: base = 16;
    endcase
    row.coil_duty_a = sps_pkg::duty_t'(COIL_TAB[base + idx][0]);
    row.coil_duty_b = sps_pkg::duty_t'(COIL_TAB[base + idx][1]);
    row.coil_duty_c = sps_pkg::duty_t'(COIL_TAB[base + idx][2]);
    row.coil_duty_d = sps_pkg::duty_t'(COIL_TAB[base + idx][3]);
    return row;
  endfunction

  // speed law, chosen by the mode in force when the update arrives
  function automatic logic [11:0] period_from_level(sps_pkg::drive_mode_t m,
                                                    logic [7:0] lvl);
    int p;
    case (m)
      sps_pkg::MODE_FULL, sps_pkg::MODE_WAVE: p = 10 * lvl + 20;
      sps_pkg::MODE_HALF: p = 10 * lvl + 10;
      default: p = 4 * lvl + 8;
    endcase
    return p[11:0];
  endfunction

  // advance the mirror by one accepted transaction, queue any coil row it emits
  task automatic step_sequencer(sps_pkg::in_t item);
    int len;
    int idx;
    case (item.req_type)
      sps_pkg::REQ_TICK: begin
        if (seq_ticks > 12'd1) begin
          seq_ticks = seq_ticks - 12'd1;
        end else begin
          len = table_rows(seq_mode);
          idx = seq_index & (len - 1);
          expected_rows.push_back(coil_row(seq_mode, idx));
          rows_predicted++;
          if (seq_forward)
            idx = (idx + 1 == len) ? 0 : idx + 1;
          else
            idx = (idx == 0) ? len - 1 : idx - 1;
          seq_index = idx[3:0];
          seq_ticks = seq_period;
        end
      end
      sps_pkg::REQ_SPEED: seq_period = period_from_level(seq_mode, item.speed_level);
      sps_pkg::REQ_DIR: seq_forward = !seq_forward;
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_row(sps_pkg::out_t got);
    sps_pkg::out_t want;
    if (expected_rows.size() == 0) begin
      report_mismatch($sformatf("coil row %h with nothing expected", got));
    end else begin
      want = expected_rows.pop_front();
      if (got.coil_duty_a !== want.coil_duty_a)
        report_mismatch($sformatf("coil_duty_a %0d, want %0d", got.coil_duty_a,
                                  want.coil_duty_a));
      if (got.coil_duty_b !== want.coil_duty_b)
        report_mismatch($sformatf("coil_duty_b %0d, want %0d", got.coil_duty_b,
                                  want.coil_duty_b));
      if (got.coil_duty_c !== want.coil_duty_c)
        report_mismatch($sformatf("coil_duty_c %0d, want %0d", got.coil_duty_c,
                                  want.coil_duty_c));
      if (got.coil_duty_d !== want.coil_duty_d)
        report_mismatch($sformatf("coil_duty_d %0d, want %0d", got.coil_duty_d,
                                  want.coil_duty_d));
    end
  endtask

  // driver: bursts of transactions with random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        step_sequencer(in_data);
      if (!in_valid || !in_stall) begin
        if (gap_left != 0 || pending_items.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left != 0)
            gap_left--;
        end else begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // monitor: check accepted rows, stall on a pattern that changes style now and then
  int stall_style = 0;
  int stall_hold = 0;
  int stall_phase = 0;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      check_row(out_data);
    if (stall_hold == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_hold = $urandom_range(32, 256);
    end else begin
      stall_hold--;
    end
    stall_phase = (stall_phase + 1) % 8;
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 30);
      2: out_stall <= ($urandom_range(0, 99) < 75);
      default: out_stall <= (stall_phase < 5);
    endcase
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic queue_item(logic [1:0] req, logic [7:0] lvl);
    sps_pkg::in_t item;
    item.req_type = req;
    item.speed_level = lvl;
    pending_items.push_back(item);
    if (req != REQ_UNUSED)
      items_queued++;
  endtask

  task automatic queue_ticks(int n);
    repeat (n) queue_item(sps_pkg::REQ_TICK, 8'($urandom_range(0, 255)));
  endtask

  // mostly ticks, speed levels mostly small so rows keep coming
  task automatic queue_random_item();
    int pick;
    int lvl_pick;
    pick = $urandom_range(0, 99);
    lvl_pick = $urandom_range(0, 99);
    if (pick < 76) begin
      queue_item(sps_pkg::REQ_TICK, 8'($urandom_range(0, 255)));
    end else if (pick < 88) begin
      if (lvl_pick < 85)
        queue_item(sps_pkg::REQ_SPEED, 8'($urandom_range(0, 7)));
      else if (lvl_pick < 97)
        queue_item(sps_pkg::REQ_SPEED, 8'($urandom_range(0, 40)));
      else
        queue_item(sps_pkg::REQ_SPEED, 8'($urandom_range(0, 255)));
    end else if (pick < 95) begin
      queue_item(sps_pkg::REQ_DIR, 8'($urandom_range(0, 255)));
    end else begin
      queue_item(REQ_UNUSED, 8'($urandom_range(0, 255)));
    end
  endtask

  // wait until every transaction is in and every row is out, then let the pipe settle
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_rows.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(sps_pkg::drive_mode_t m);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    seq_mode = m;
    seq_index = 4'd0;
  endtask

  // stimulus
  initial begin
    int phase;
    sps_pkg::drive_mode_t next_mode;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset mode: ignored request, extreme levels, direction flips and the backward wrap
    queue_item(REQ_UNUSED, 8'hff);
    queue_item(sps_pkg::REQ_SPEED, 8'd255);
    queue_item(sps_pkg::REQ_SPEED, 8'd0);
    queue_item(sps_pkg::REQ_DIR, 8'h00);
    queue_item(sps_pkg::REQ_DIR, 8'haa);
    queue_ticks(50);
    queue_item(sps_pkg::REQ_DIR, 8'h55);
    queue_ticks(24);
    queue_item(sps_pkg::REQ_DIR, 8'hff);
    queue_ticks(8);
    queue_item(sps_pkg::REQ_TICK, 8'h00);
    queue_item(sps_pkg::REQ_TICK, 8'hff);

    // random phases, each under its own drive mode
    phase = 0;
    while ((items_queued < MIN_ITEMS || rows_predicted < MIN_ROWS) &&
           items_queued < MAX_ITEMS) begin
      wait_drained();
      case (phase)
        0: next_mode = sps_pkg::MODE_FULL;
        1: next_mode = sps_pkg::MODE_WAVE;
        2: next_mode = sps_pkg::MODE_HALF;
        3: next_mode = sps_pkg::MODE_MICRO;
        default: next_mode = sps_pkg::drive_mode_t'($urandom_range(0, 3));
      endcase
      write_mode(next_mode);
      repeat ($urandom_range(40, 200)) queue_random_item();
      phase++;
    end

    wait_drained();
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
